// ===== rtl/tss_pkg.sv =====
// package for the regression tree split sweep block
// holds widths, item kinds, register indexes, controller states and command/status structs; no dependencies
package tss_pkg;
  localparam int NumFeat = 16;
  localparam int NumIntv = 1024;
  localparam int MaxRows = 4096;
  localparam int FeatW = 4;
  localparam int IntvW = 10;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RISK = 2'd1,
    KIND_ELEM = 2'd2,
    KIND_FIN  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_MINC = 2'd1;
  localparam logic [1:0] REG_SPLIT = 2'd2;
  localparam logic [1:0] REG_INTV = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_PREP, ST_DIV, ST_ACC, ST_ROW, ST_SNAP, ST_EMIT, ST_CLEAR
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       do_load;
    logic       do_risk;
    logic       mem_rd;
    logic       prep;
    logic [1:0] div_sel;
    logic       div_start;
    logic       acc;
    logic       wr_back;
    logic       end_row;
    logic       snap;
    logic       emit;
    logic       clear;
  } tss_cmd_t;

  typedef struct packed {
    logic       move_ok;
    logic       row_end;
    logic       div_done;
    logic [1:0] kind;
  } tss_sts_t;
endpackage

// ===== rtl/tss_div.sv =====
// radix-2 restoring divider, 80-bit dividend by 13-bit divisor
// uses tss_pkg; one quotient bit per cycle
module tss_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [79:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [79:0] quotient
);
  import tss_pkg::*;
  logic [79:0] q;
  logic [13:0] rem;
  logic [12:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [13:0] shifted;

  assign shifted = {rem[12:0], q[79]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd79) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= shifted - {1'b0, dvs};
        q <= {q[78:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[78:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/tss_datapath.sv =====
// datapath: config registers, interval memories, feature risks, sse unit, best tracking, output register
// uses tss_pkg and tss_div
module tss_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tss_pkg::tss_cmd_t   cmd,
  output tss_pkg::tss_sts_t   sts,
  input  logic [1:0]          kind,
  input  logic [3:0]          feature,
  input  logic [10:0]         interval,
  input  logic signed [23:0]  local_effect,
  input  logic [12:0]         total_count,
  input  logic signed [35:0]  total_sum,
  input  logic [57:0]         total_square_sum,
  input  logic [57:0]         initial_risk,
  input  logic                is_candidate,
  input  logic                row_end,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic [3:0]          emit_idx,
  output logic [3:0]          out_feature,
  output logic [57:0]         left_risk,
  output logic [57:0]         right_risk,
  output logic [11:0]         best_position,
  output logic [62:0]         best_total,
  output logic                found,
  output logic                last
);
  import tss_pkg::*;

  logic [12:0] row_count, min_child_rows, interval_count;
  logic [4:0]  split_feature;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 13'd2;
      min_child_rows <= 13'd1;
      split_feature <= '0;
      interval_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:  row_count <= cfg_data;
        REG_MINC:  min_child_rows <= cfg_data;
        REG_SPLIT: split_feature <= cfg_data[4:0];
        REG_INTV:  interval_count <= {2'b0, cfg_data[10:0]};
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  k_q;
  logic [3:0]  f_q;
  logic [10:0] i_q;
  logic signed [23:0] d_q;
  logic [12:0] tc_q;
  logic [35:0] ts_q;
  logic [57:0] tq_q, ir_q;
  logic        cand_q, rend_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k_q <= kind; f_q <= feature; i_q <= interval; d_q <= local_effect;
      tc_q <= total_count; ts_q <= total_sum; tq_q <= total_square_sum;
      ir_q <= initial_risk; cand_q <= is_candidate; rend_q <= row_end;
    end
  end

  logic iv;
  assign iv = ({2'b0, i_q} < interval_count) && !i_q[10];
  logic [IntvW-1:0] ia;
  assign ia = i_q[IntvW-1:0];

  // interval memories: node and right statistics
  logic [12:0] mem_tn [NumIntv];
  logic [35:0] mem_ts [NumIntv];
  logic [57:0] mem_tq [NumIntv];
  logic [12:0] mem_rn [NumIntv];
  logic [35:0] mem_rs [NumIntv];
  logic [57:0] mem_rq [NumIntv];
  logic [12:0] tn, rn;
  logic [35:0] ts1, rs1;
  logic [57:0] ts2, rs2;

  logic [35:0] rs1n;
  logic [57:0] rs2n;

  always_ff @(posedge clk) begin
    if (cmd.do_load && iv) begin
      mem_tn[ia] <= tc_q; mem_ts[ia] <= ts_q; mem_tq[ia] <= tq_q;
    end
    if ((cmd.do_load && iv) || cmd.wr_back) begin
      mem_rn[ia] <= cmd.do_load ? tc_q : rn - 13'd1;
      mem_rs[ia] <= cmd.do_load ? ts_q : rs1n;
      mem_rq[ia] <= cmd.do_load ? tq_q : rs2n;
    end
    if (cmd.mem_rd) begin
      tn <= mem_tn[ia]; ts1 <= mem_ts[ia]; ts2 <= mem_tq[ia];
      rn <= mem_rn[ia]; rs1 <= mem_rs[ia]; rs2 <= mem_rq[ia];
    end
  end

  // prep: four sse operand sets
  logic [23:0] dmag;
  logic [47:0] dd;
  logic [12:0] n_op [4];
  logic [36:0] s1_op [4];
  logic [57:0] s2_op [4];
  logic [63:0] sse_v [4];
  logic [12:0] ln, ln2;
  logic [57:0] ls2, ls2n;

  assign dmag = d_q[23] ? 24'(-d_q) : d_q;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dd <= {24'b0, dmag} * {24'b0, dmag};
      rs1n <= rs1 - 36'($signed(d_q));
    end
  end

  always_comb begin
    rs2n = (rs2 >= {10'b0, dd}) ? rs2 - {10'b0, dd} : '0;
    ln = (tn >= rn) ? tn - rn : '0;
    ln2 = (tn >= rn - 13'd1) ? tn - (rn - 13'd1) : '0;
    ls2 = (ts2 >= rs2) ? ts2 - rs2 : '0;
    ls2n = (ts2 >= rs2n) ? ts2 - rs2n : '0;
    n_op[0] = rn;         s1_op[0] = {rs1[35], rs1};   s2_op[0] = rs2;
    n_op[1] = rn - 13'd1; s1_op[1] = {rs1n[35], rs1n}; s2_op[1] = rs2n;
    n_op[2] = ln;  s1_op[2] = {ts1[35], ts1} - {rs1[35], rs1};   s2_op[2] = ls2;
    n_op[3] = ln2; s1_op[3] = {ts1[35], ts1} - {rs1n[35], rs1n}; s2_op[3] = ls2n;
  end

  // shared squaring unit and divider
  logic [36:0] mag;
  logic [71:0] sq;
  logic [79:0] quo;
  logic        dv_done;
  logic [12:0] n_cur;
  logic [57:0] s2_cur;
  logic [36:0] s1_cur;
  assign n_cur = n_op[cmd.div_sel];
  assign s1_cur = s1_op[cmd.div_sel];
  assign s2_cur = s2_op[cmd.div_sel];
  assign mag = s1_cur[36] ? 37'(-s1_cur) : s1_cur;
  assign sq = {35'b0, mag} * {35'b0, mag};

  tss_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend({8'b0, sq}),
    .divisor(n_cur), .done(dv_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (dv_done) begin
      if (n_cur <= 13'd1 || quo > {22'b0, s2_cur}) sse_v[cmd.div_sel] <= '0;
      else sse_v[cmd.div_sel] <= {6'b0, s2_cur - quo[57:0]};
    end
  end

  // feature risks and best tracking
  logic [63:0] lrisk [NumFeat];
  logic [63:0] rrisk [NumFeat];
  logic [63:0] lsnap [NumFeat];
  logic [63:0] rsnap [NumFeat];
  logic [63:0] run_total, best_obj;
  logic [12:0] best_row, pos;
  logic        found_q;
  logic        self_ex;
  logic [3:0]  j0;
  logic [63:0] tot_c;
  logic [12:0] pos_n;
  logic        ok_c;

  assign self_ex = (split_feature >= 5'd1) && (split_feature <= 5'd16);
  assign j0 = 4'(split_feature - 5'd1);
  assign pos_n = (pos != 13'h1FFF) ? pos + 13'd1 : pos;

  always_comb begin
    tot_c = run_total;
    if (self_ex) tot_c = run_total - lrisk[j0] - rrisk[j0];
    ok_c = cand_q && pos != 13'd0 && pos < row_count && pos < 13'(MaxRows)
        && pos >= min_child_rows && (row_count - pos) >= min_child_rows
        && (!found_q || tot_c < best_obj);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int k = 0; k < NumFeat; k++) begin
        lrisk[k] <= '0; rrisk[k] <= '0; lsnap[k] <= '0; rsnap[k] <= '0;
      end
      run_total <= '0; best_obj <= '1; best_row <= '0; pos <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd.do_risk) begin
        run_total <= run_total - rrisk[f_q] + {6'b0, ir_q};
        rrisk[f_q] <= {6'b0, ir_q};
      end
      if (cmd.acc) begin
        rrisk[f_q] <= rrisk[f_q] - sse_v[0] + sse_v[1];
        lrisk[f_q] <= lrisk[f_q] - sse_v[2] + sse_v[3];
        run_total <= run_total - sse_v[2] - sse_v[0] + sse_v[3] + sse_v[1];
      end
      if (cmd.end_row) begin
        pos <= pos_n;
      end
      if (cmd.snap) begin
        if (ok_c) begin
          found_q <= 1'b1; best_obj <= tot_c; best_row <= pos;
          for (int k = 0; k < NumFeat; k++) begin
            lsnap[k] <= (self_ex && j0 == 4'(k)) ? '0 : lrisk[k];
            rsnap[k] <= (self_ex && j0 == 4'(k)) ? '0 : rrisk[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_feature <= emit_idx;
      left_risk <= found_q ? lsnap[emit_idx][57:0] : '0;
      right_risk <= found_q ? rsnap[emit_idx][57:0] : '0;
      best_position <= found_q ? (best_row > 13'd4095 ? 12'hFFF : best_row[11:0]) : '0;
      best_total <= (found_q && !best_obj[63]) ? best_obj[62:0] : '1;
      found <= found_q;
      last <= (emit_idx == 4'(NumFeat - 1));
    end
  end

  assign sts.move_ok = iv && rn != 13'd0;
  assign sts.row_end = rend_q;
  assign sts.div_done = dv_done;
  assign sts.kind = k_q;

  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.end_row && pos != 13'h1FFF |=> pos == $past(pos) + 13'd1 || cmd.clear)
    else $error("position step");
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    $past(found_q) && !cmd.clear && !$past(cmd.clear) |-> best_obj <= $past(best_obj))
    else $error("best not monotonic");
  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    found_q && !cmd.clear |=> found_q)
    else $error("found dropped");
endmodule

// ===== rtl/tss_ctrl.sv =====
// controller state machine for the split sweep
// uses tss_pkg; drives tss_datapath commands
module tss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tss_pkg::tss_sts_t sts,
  output tss_pkg::tss_cmd_t cmd,
  output logic [3:0]        emit_idx
);
  import tss_pkg::*;
  state_t state, state_next;
  logic [3:0] idx;
  logic ov;
  logic out_free;
  logic [1:0] dsel;
  logic div_go;

  assign out_free = !ov || out_ready;
  assign out_valid = ov;
  assign emit_idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; idx <= '0; ov <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        ov <= 1'b1;
        idx <= idx + 4'd1;
      end else if (out_ready) ov <= 1'b0;
      if (state == ST_IDLE) idx <= '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ: begin
        case (kind_t'(sts.kind))
          KIND_FIN:  state_next = ST_EMIT;
          KIND_ELEM: state_next = ST_PREP;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_PREP:  state_next = sts.move_ok ? ST_DIV : ST_ROW;
      ST_DIV:   if (sts.div_done) state_next = (dsel == 2'd3) ? ST_ACC : ST_DIV;
      ST_ACC:   state_next = ST_ROW;
      ST_ROW:   state_next = sts.row_end ? ST_SNAP : ST_IDLE;
      ST_SNAP:  state_next = ST_IDLE;
      ST_EMIT:  if (out_free && idx == 4'(NumFeat - 1)) state_next = ST_CLEAR;
      ST_CLEAR: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) dsel <= '0;
    else if (state == ST_PREP) dsel <= '0;
    else if (state == ST_DIV && sts.div_done && dsel != 2'd3) dsel <= dsel + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= (state == ST_PREP && sts.move_ok)
        || (state == ST_DIV && sts.div_done && dsel != 2'd3);
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    cmd.load_item = (state == ST_IDLE) && in_valid;
    cmd.div_sel = dsel;
    case (state)
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        cmd.do_load = (kind_t'(sts.kind) == KIND_LOAD);
        cmd.do_risk = (kind_t'(sts.kind) == KIND_RISK);
      end
      ST_PREP:  cmd.prep = 1'b1;
      ST_DIV:   cmd.div_start = div_go;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.wr_back = 1'b1;
      end
      ST_ROW:   cmd.end_row = sts.row_end;
      ST_SNAP:  cmd.snap = 1'b1;
      ST_EMIT:  cmd.emit = out_free;
      ST_CLEAR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == ST_EMIT)
    else $error("emit outside emit state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("ready while busy");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> $past(state) == ST_EMIT)
    else $error("clear out of order");
endmodule

// ===== rtl/tree_split_sse_sweep_top.sv =====
// channel   | handshake             | payload
// in        | in_valid/in_ready     | kind .. row_end
// out       | out_valid/out_ready   | out_feature .. last
// cfg       | cfg_we                | cfg_index, cfg_data
// loads pass through the read state alone; an element that moves runs the shared
// bit-serial divider once for each of the four sse terms, in turn; a finish emits
// 16 beats, one per cycle while out_ready is high, then passes through the clear state.
// reset is synchronous; interval memories are not cleared and are undefined until loaded.
// top level of the split sweep; uses tss_pkg, tss_ctrl, tss_datapath
module tree_split_sse_sweep_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [3:0]         feature,
  input  logic [10:0]        interval,
  input  logic signed [23:0] local_effect,
  input  logic [12:0]        total_count,
  input  logic signed [35:0] total_sum,
  input  logic [57:0]        total_square_sum,
  input  logic [57:0]        initial_risk,
  input  logic               is_candidate,
  input  logic               row_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_feature,
  output logic [57:0]        left_risk,
  output logic [57:0]        right_risk,
  output logic [11:0]        best_position,
  output logic [62:0]        best_total,
  output logic               found,
  output logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import tss_pkg::*;
  tss_cmd_t cmd;
  tss_sts_t sts;
  logic [3:0] emit_idx;

  tss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd),
    .emit_idx(emit_idx)
  );

  tss_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .kind(kind), .feature(feature),
    .interval(interval), .local_effect(local_effect), .total_count(total_count),
    .total_sum(total_sum), .total_square_sum(total_square_sum),
    .initial_risk(initial_risk), .is_candidate(is_candidate), .row_end(row_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .emit_idx(emit_idx),
    .out_feature(out_feature), .left_risk(left_risk), .right_risk(right_risk),
    .best_position(best_position), .best_total(best_total), .found(found), .last(last)
  );
endmodule
